[src/e10sp_pkg.sv]
// shared constants and types for the exp10 single-precision core
`timescale 1ns / 1ps
`default_nettype none
package e10sp_pkg;

    localparam int unsigned FP_W = 32;

    // polynomial coefficients and reduction constants, binary32 patterns
    localparam logic [FP_W-1:0] C0_BITS       = 32'h40135d8b;
    localparam logic [FP_W-1:0] C1_BITS       = 32'h4029a869;
    localparam logic [FP_W-1:0] C2_BITS       = 32'h40023a25;
    localparam logic [FP_W-1:0] C3_BITS       = 32'h3f96c0bb;
    localparam logic [FP_W-1:0] C4_BITS       = 32'h3f095a0d;
    localparam logic [FP_W-1:0] INV_L2_BITS   = 32'h40549a78;
    localparam logic [FP_W-1:0] L2_HI_BITS    = 32'h3e9a209b;
    localparam logic [FP_W-1:0] L2_LO_BITS    = 32'h32760860;
    localparam logic [FP_W-1:0] SPLIT_OFFSET  = 32'h82000000;
    localparam logic [FP_W-1:0] SPLIT_BIAS    = 32'h7f000000;
    localparam logic [FP_W-1:0] ONE_BITS      = 32'h3f800000;
    localparam logic [FP_W-1:0] NEG_ZERO_BITS = 32'h80000000;
    localparam logic [FP_W-1:0] QNAN_BITS     = 32'h7fc00000;
    localparam logic [FP_W-1:0] QUIET_BIT     = 32'h00400000;
    localparam logic [30:0]     INF_MAG       = 31'h7f800000;

    // |n| bounds for the split and saturation paths
    localparam logic [8:0] SPLIT_BOUND = 9'd126;
    localparam logic [8:0] SAT_BOUND   = 9'd192;

    // per-beat side data that travels down the pipeline
    typedef struct packed {
        logic            valid;
        logic [FP_W-1:0] x;
        logic            nneg;
        logic            sat;
        logic            split;
        logic [FP_W-1:0] nf;
        logic [8:0]      ni;
        logic [FP_W-1:0] rr;
        logic [FP_W-1:0] rc0;
        logic [FP_W-1:0] t;
    } meta_t;

endpackage
`default_nettype wire

[src/e10sp_fma.sv]
// three-stage binary32 fused multiply-add, round to nearest even
`timescale 1ns / 1ps
`default_nettype none
module e10sp_fma (
    input  wire logic        aclk,
    input  wire logic        ce,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] c,
    output logic      [31:0] y
);

    // stage 1: unpack and multiply
    logic        a_sub, b_sub, c_sub;
    logic [7:0]  ea, eb, ec;
    logic [23:0] ma, mb, mc;
    logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero;
    logic [47:0] mp;
    logic [47:0] mp_k;
    logic        sp;
    logic signed [11:0] s_prod;
    logic signed [11:0] s_sum;
    logic        nan_o, inf_o, infs_o;

    always_comb begin
        a_sub  = (a[30:23] == 8'd0);
        b_sub  = (b[30:23] == 8'd0);
        c_sub  = (c[30:23] == 8'd0);
        ea     = a_sub ? 8'd1 : a[30:23];
        eb     = b_sub ? 8'd1 : b[30:23];
        ec     = c_sub ? 8'd1 : c[30:23];
        ma     = {~a_sub, a[22:0]};
        mb     = {~b_sub, b[22:0]};
        mc     = {~c_sub, c[22:0]};
        a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        c_nan  = (c[30:23] == 8'hff) && (c[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        c_inf  = (c[30:23] == 8'hff) && (c[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        mp     = ma * mb;
        sp     = a[31] ^ b[31];
        s_prod = $signed({4'd0, ea}) + $signed({4'd0, eb});
        // a zero product is parked right under c so c passes through exactly
        if (mp == 48'd0) begin
            s_sum = $signed({4'd0, ec}) + 12'sd100;
            mp_k  = mp;
        end else if ((s_prod - $signed({4'd0, ec}) - 12'sd100 < 12'sd0)
                     && (c[30:0] != 31'd0)) begin
            // product far below c: it only counts as sticky under the round bit
            s_sum = $signed({4'd0, ec}) + 12'sd100;
            mp_k  = 48'd1;
        end else begin
            s_sum = s_prod;
            mp_k  = mp;
        end
        nan_o  = a_nan || b_nan || c_nan || (a_inf && b_zero) || (b_inf && a_zero)
                 || ((a_inf || b_inf) && c_inf && (sp != c[31]));
        inf_o  = a_inf || b_inf || c_inf;
        infs_o = (a_inf || b_inf) ? sp : c[31];
    end

    logic [47:0]        s1_mp_reg;
    logic               s1_sp_reg, s1_sc_reg;
    logic signed [11:0] s1_s_reg;
    logic [7:0]         s1_ec_reg;
    logic [23:0]        s1_mc_reg;
    logic               s1_nan_reg, s1_inf_reg, s1_infs_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_mp_reg   <= mp_k;
            s1_sp_reg   <= sp;
            s1_sc_reg   <= c[31];
            s1_s_reg    <= s_sum;
            s1_ec_reg   <= ec;
            s1_mc_reg   <= mc;
            s1_nan_reg  <= nan_o;
            s1_inf_reg  <= inf_o;
            s1_infs_reg <= infs_o;
        end
    end

    // stage 2: align addend and add; bit 0 of the window collects sticky
    logic signed [11:0] sh;
    logic [6:0]         shc;
    logic [151:0]       c_wide;
    logic [75:0]        c_al, p_al;
    logic [76:0]        d_add, d_sub, mag;
    logic               neg, rsign;

    always_comb begin
        sh = s1_s_reg - $signed({4'd0, s1_ec_reg}) - 12'sd100;
        if (sh < 12'sd0) begin
            shc = 7'd0;
        end else if (sh > 12'sd76) begin
            shc = 7'd76;
        end else begin
            shc = sh[6:0];
        end
        c_wide = {s1_mc_reg, 128'd0} >> shc;
        c_al   = c_wide[151:76] | {75'd0, |c_wide[75:0]};
        p_al   = {26'd0, s1_mp_reg, 2'd0};
        d_add  = {1'b0, p_al} + {1'b0, c_al};
        d_sub  = {1'b0, p_al} - {1'b0, c_al};
        neg    = d_sub[76];
        if (s1_sp_reg == s1_sc_reg) begin
            mag   = d_add;
            rsign = s1_sp_reg;
        end else begin
            mag   = neg ? (77'd0 - d_sub) : d_sub;
            rsign = neg ? s1_sc_reg : s1_sp_reg;
        end
    end

    logic [76:0]        s2_mag_reg;
    logic               s2_sign_reg, s2_zsign_reg;
    logic signed [11:0] s2_s_reg;
    logic               s2_nan_reg, s2_inf_reg, s2_infs_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_mag_reg   <= mag;
            s2_sign_reg  <= rsign;
            s2_zsign_reg <= s1_sp_reg & s1_sc_reg;
            s2_s_reg     <= s1_s_reg;
            s2_nan_reg   <= s1_nan_reg;
            s2_inf_reg   <= s1_inf_reg;
            s2_infs_reg  <= s1_infs_reg;
        end
    end

    // stage 3: normalize, handle subnormal range, round and pack
    logic [6:0]         lead;
    logic signed [11:0] lmax, lwant, lsh, ebias;
    logic [6:0]         rsh;
    logic [153:0]       r_wide;
    logic [76:0]        norm;
    logic               rsticky, g, st, inc, ovf;
    logic [30:0]        word, rounded;

    always_comb begin
        lead = 7'd0;
        for (int i = 0; i < 77; i++) begin
            if (s2_mag_reg[i]) begin
                lead = 7'(i);
            end
        end
        lmax    = s2_s_reg - 12'sd100;
        lwant   = 12'sd76 - $signed({5'd0, lead});
        lsh     = (lwant < lmax) ? lwant : lmax;
        rsh     = 7'd0;
        rsticky = 1'b0;
        r_wide  = '0;
        if (lmax >= 12'sd0) begin
            norm = s2_mag_reg << lsh[6:0];
        end else begin
            lsh     = 12'sd0;
            rsh     = (lmax < -12'sd100) ? 7'd100 : 7'(-lmax);
            r_wide  = {s2_mag_reg, 77'd0} >> rsh;
            norm    = r_wide[153:77];
            rsticky = |r_wide[76:0];
        end
        ebias = s2_s_reg - 12'sd99 - lsh;
        ovf   = norm[76] && (ebias >= 12'sd255);
        word  = {(norm[76] ? ebias[7:0] : 8'd0), norm[75:53]};
        g     = norm[52];
        st    = (|norm[51:0]) | rsticky;
        inc   = g && (st || norm[53]);
        rounded = word + {30'd0, inc};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (s2_nan_reg) begin
                y <= e10sp_pkg::QNAN_BITS;
            end else if (s2_inf_reg) begin
                y <= {s2_infs_reg, e10sp_pkg::INF_MAG};
            end else if (s2_mag_reg == 77'd0) begin
                y <= {s2_zsign_reg, 31'd0};
            end else if (ovf) begin
                y <= {s2_sign_reg, e10sp_pkg::INF_MAG};
            end else begin
                y <= {s2_sign_reg, rounded};
            end
        end
    end

endmodule
`default_nettype wire

[src/exp10_single_precision_core.sv]
// top level of the exp10 single-precision core
`timescale 1ns / 1ps
`default_nettype none
// Computes y = 10^x for one binary32 value per beat, bit-exact with round to
// nearest even on every floating-point step and one rounding per fused
// multiply-add. The core is a pipeline built from eight chained levels of a
// three-stage fused multiply-add unit plus a registered result select; it
// accepts one beat per clock while the result side is not stalled. A stall on
// the result side freezes the whole pipeline, so s_tready follows m_tready
// while a result is waiting. NaN inputs come back quieted, large positive x
// saturates to +inf and large negative x to +0.
module exp10_single_precision_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] x_bits
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [31:0] y_bits
);

    localparam int unsigned DEPTH  = 25;
    localparam int unsigned ST_N   = 3;
    localparam int unsigned ST_R1  = 6;
    localparam int unsigned ST_R   = 9;
    localparam int unsigned ST_P   = 12;
    localparam int unsigned ST_P14 = 15;
    localparam int unsigned ST_PLY = 18;
    localparam int unsigned ST_T   = 21;
    localparam int unsigned ST_Y   = 24;

    e10sp_pkg::meta_t meta_reg  [DEPTH];
    e10sp_pkg::meta_t meta_next [DEPTH];

    logic        ce;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic [31:0] m_y, r1_y, r_y, rr_y, p12_y, p34_y, rc0_y, p14_y, poly_y, t_y, y8_y;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // n = round half away of x / log10(2), kept as 9-bit magnitude
    logic [7:0]  me;
    logic        big;
    logic [4:0]  rshamt;
    logic [23:0] rv;
    logic [9:0]  k10;
    logic [8:0]  kmag;
    logic [3:0]  klead;
    logic [31:0] kshift;
    logic [31:0] nf_c;
    logic [8:0]  ni_c;

    always_comb begin
        me     = m_y[30:23];
        big    = (me >= 8'd135);
        rshamt = 5'(8'd149 - me);
        rv     = {1'b1, m_y[22:0]} >> rshamt;
        k10    = {1'b0, rv[8:0]} + 10'd1;
        kmag   = (me < 8'd126) ? 9'd0 : k10[9:1];
        klead  = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (kmag[i]) begin
                klead = 4'(i);
            end
        end
        kshift = {23'd0, kmag} << (5'd23 - {1'b0, klead});
        if (kmag == 9'd0) begin
            nf_c = {m_y[31], 31'd0};
        end else begin
            nf_c = {m_y[31], 8'd127 + {4'd0, klead}, kshift[22:0]};
        end
        ni_c = m_y[31] ? (9'd0 - kmag) : kmag;
    end

    // scale factors for the final two multiply-adds
    logic [31:0] e18, scale18, s2_18, sel18, s1_21;

    always_comb begin
        e18     = {meta_reg[ST_PLY].ni, 23'd0};
        scale18 = e18 + e10sp_pkg::ONE_BITS;
        s2_18   = meta_reg[ST_PLY].nneg ? (e18 - e10sp_pkg::SPLIT_OFFSET) : e18;
        sel18   = meta_reg[ST_PLY].split ? s2_18 : scale18;
        s1_21   = meta_reg[ST_T].nneg ? (e10sp_pkg::SPLIT_OFFSET + e10sp_pkg::SPLIT_BIAS)
                                      : e10sp_pkg::SPLIT_BIAS;
    end

    always_comb begin
        meta_next[0]       = '0;
        meta_next[0].valid = s_tvalid;
        meta_next[0].x     = s_tdata;
        for (int k = 1; k < DEPTH; k++) begin
            meta_next[k] = meta_reg[k-1];
        end
        meta_next[ST_N].nneg  = m_y[31];
        meta_next[ST_N].sat   = big || (kmag > e10sp_pkg::SAT_BOUND);
        meta_next[ST_N].split = kmag > e10sp_pkg::SPLIT_BOUND;
        meta_next[ST_N].nf    = nf_c;
        meta_next[ST_N].ni    = ni_c;
        meta_next[ST_P+1].rr  = rr_y;
        meta_next[ST_P+1].rc0 = rc0_y;
        meta_next[ST_T+1].t   = t_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                meta_reg[k].valid <= 1'b0;
            end
        end else if (ce) begin
            for (int k = 0; k < DEPTH; k++) begin
                meta_reg[k] <= meta_next[k];
            end
        end
    end

    e10sp_fma u_fma_m (.aclk, .ce, .a(s_tdata), .b(e10sp_pkg::INV_L2_BITS),
                       .c(e10sp_pkg::NEG_ZERO_BITS), .y(m_y));
    e10sp_fma u_fma_r1 (.aclk, .ce,
                        .a(meta_reg[ST_N].nf ^ e10sp_pkg::NEG_ZERO_BITS),
                        .b(e10sp_pkg::L2_HI_BITS), .c(meta_reg[ST_N].x), .y(r1_y));
    e10sp_fma u_fma_r (.aclk, .ce, .a(meta_reg[ST_R1].nf), .b(e10sp_pkg::L2_LO_BITS),
                       .c(r1_y), .y(r_y));
    e10sp_fma u_fma_rr (.aclk, .ce, .a(r_y), .b(r_y), .c(e10sp_pkg::NEG_ZERO_BITS),
                        .y(rr_y));
    e10sp_fma u_fma_p12 (.aclk, .ce, .a(r_y), .b(e10sp_pkg::C2_BITS),
                         .c(e10sp_pkg::C1_BITS), .y(p12_y));
    e10sp_fma u_fma_p34 (.aclk, .ce, .a(r_y), .b(e10sp_pkg::C4_BITS),
                         .c(e10sp_pkg::C3_BITS), .y(p34_y));
    e10sp_fma u_fma_rc0 (.aclk, .ce, .a(r_y), .b(e10sp_pkg::C0_BITS),
                         .c(e10sp_pkg::NEG_ZERO_BITS), .y(rc0_y));
    e10sp_fma u_fma_p14 (.aclk, .ce, .a(rr_y), .b(p34_y), .c(p12_y), .y(p14_y));
    e10sp_fma u_fma_poly (.aclk, .ce, .a(p14_y), .b(meta_reg[ST_P14].rr),
                          .c(meta_reg[ST_P14].rc0), .y(poly_y));
    e10sp_fma u_fma_t (.aclk, .ce, .a(poly_y), .b(sel18), .c(sel18), .y(t_y));
    e10sp_fma u_fma_y (.aclk, .ce, .a(t_y), .b(s1_21), .c(e10sp_pkg::NEG_ZERO_BITS),
                       .y(y8_y));

    // result select: quiet nan, saturation, split product or direct fma
    logic        x_nan;
    logic [31:0] y_sel;

    always_comb begin
        x_nan = (meta_reg[ST_Y].x[30:23] == 8'hff) && (meta_reg[ST_Y].x[22:0] != 23'd0);
        if (x_nan) begin
            y_sel = meta_reg[ST_Y].x | e10sp_pkg::QUIET_BIT;
        end else if (meta_reg[ST_Y].sat) begin
            y_sel = meta_reg[ST_Y].nneg ? 32'd0 : {1'b0, e10sp_pkg::INF_MAG};
        end else if (meta_reg[ST_Y].split) begin
            y_sel = y8_y;
        end else begin
            y_sel = meta_reg[ST_Y].t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= meta_reg[ST_Y].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= y_sel;
        end
    end

    // a waiting result must hold the whole pipeline
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_n_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (meta_reg[ST_N].valid && !meta_reg[ST_N].sat) |->
        ($signed(meta_reg[ST_N].ni) <= 9'sd192 && $signed(meta_reg[ST_N].ni) >= -9'sd192))
        else $error("exponent out of range on the scaled path");

    a_direct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (meta_reg[ST_N].valid && !meta_reg[ST_N].sat && !meta_reg[ST_N].split) |->
        ($signed(meta_reg[ST_N].ni) <= 9'sd126 && $signed(meta_reg[ST_N].ni) >= -9'sd126))
        else $error("exponent out of range on the direct path");

endmodule
`default_nettype wire
